/* sv/assert_macros.svh */
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

/* sv/abkf_pkg.sv */
// package of constants and types for the angle bias kalman filter
`default_nettype none
package abkf_pkg;
   localparam int DATA_WIDTH    = 32;
   localparam int RATE_WIDTH    = 16;
   localparam int CFG_FRAC_BITS = 24;
   localparam int COV_FRAC_BITS = 24;
   localparam int CSR_IDX_WIDTH = 2;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ANGLE_NOISE = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_BIAS_NOISE  = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MEAS_NOISE  = 2'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_TIME_STEP   = 2'd3;

   localparam logic [31:0] RST_ANGLE_NOISE = 32'd16777;
   localparam logic [31:0] RST_BIAS_NOISE  = 32'd50332;
   localparam logic [31:0] RST_MEAS_NOISE  = 32'd8388608;
   localparam logic [31:0] RST_TIME_STEP   = 32'd335544;

   typedef logic signed [DATA_WIDTH-1:0] word_type;

   // divider control
   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [63:0] divisor;
   } div_req_type;

   function automatic logic signed [65:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) return 66'sd2147483647;
      if (v < -66'sd2147483648) return -66'sd2147483648;
      return v;
   endfunction
endpackage
`default_nettype wire

/* sv/abkf_stream_if.sv */
// valid ready stream interface
`default_nettype none
interface abkf_stream_if #(parameter int WIDTH = 64) (input wire logic clock);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/angle_bias_kalman_filter_unit.sv */
// Two-state tilt angle / gyro bias Kalman filter. One sample is taken at a time:
// req_ready drops after a beat is accepted and the step runs on one shared 33x33
// magnitude multiplier (one product per cycle, registered) under a sequencer,
// plus a restoring divider used for both gains in sequence. The result is
// registered in the same cycle that req_ready rises again, so the next beat can
// be taken as soon as the result appears. When the innovation variance is not
// positive both divides are skipped. The result waits in an output register;
// the next step may run meanwhile and holds in its last state only while an
// earlier result is still waiting there.
`default_nettype none
`include "assert_macros.svh"
module angle_bias_kalman_filter_unit #(
   parameter int COV_FRAC_BITS = abkf_pkg::COV_FRAC_BITS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   abkf_stream_if.sink      req,
   abkf_stream_if.source    rsp,
   input  wire logic        csr_write,
   input  wire logic [abkf_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  wire logic [31:0] csr_data
);
   localparam int CF = abkf_pkg::CFG_FRAC_BITS;

   localparam logic [4:0] ST_IDLE = 5'd0,  ST_M_ANG = 5'd1,  ST_A_ANG = 5'd2,
                          ST_M_P00 = 5'd3, ST_A_P00 = 5'd4, ST_M_P01 = 5'd5,
                          ST_A_P01 = 5'd6, ST_M_P10 = 5'd7, ST_A_P10 = 5'd8,
                          ST_M_P11 = 5'd9, ST_A_P11 = 5'd10, ST_DIV0 = 5'd11,
                          ST_W0 = 5'd12,  ST_DIV1 = 5'd13,  ST_W1 = 5'd14,
                          ST_M_N00 = 5'd15, ST_A_N00 = 5'd16, ST_M_N01 = 5'd17,
                          ST_A_N01 = 5'd18, ST_M_N10 = 5'd19, ST_A_N10 = 5'd20,
                          ST_M_N11 = 5'd21, ST_A_N11 = 5'd22, ST_M_CA = 5'd23,
                          ST_A_CA = 5'd24, ST_M_CB = 5'd25, ST_A_CB = 5'd26,
                          ST_OUT = 5'd27;

   logic [4:0] st_ff, st_in;
   logic [31:0] qa_ff, qb_ff, r_ff, dt_ff;
   logic signed [31:0] ang_ff, ang_in, bias_ff, bias_in;
   logic signed [31:0] p_ff [4];
   logic signed [31:0] p_in [4];
   logic signed [31:0] meas_ff, meas_in, gyro_ff, gyro_in;
   logic signed [31:0] pa_ff, pa_in;
   logic signed [31:0] k0_ff, k0_in, k1_ff, k1_in;
   logic signed [32:0] err_ff, err_in;
   logic               epos_ff, epos_in;
   logic [63:0]        e_ff, e_in;
   logic               pneg_ff;
   logic               out_valid_ff, out_valid_in;
   logic signed [31:0] out_ang_ff, out_ang_in;
   logic signed [15:0] out_rate_ff, out_rate_in;
   logic signed [32:0] ma_in, mb_in;
   logic               mneg_ff;
   logic [65:0]        prod_ff;
   logic [6:0]         msh_in, msh_ff;
   logic               mneg_in;
   logic signed [65:0] mres;
   abkf_pkg::div_req_type div_req;
   logic               div_busy;
   logic [63:0]        div_quo;
   logic signed [65:0] qa_c, qb_c, r_c, t0, t1;
   logic signed [33:0] rate;
   logic [33:0]        rmag;
   logic signed [33:0] whole;

   function automatic logic signed [65:0] cfg_cov(input logic [31:0] v);
      if (COV_FRAC_BITS >= CF) return $signed({34'd0, v}) <<< (COV_FRAC_BITS - CF);
      return $signed({34'd0, v}) >>> (CF - COV_FRAC_BITS);
   endfunction

   abkf_divider u_div (
      .clock(clock), .reset(reset), .req(div_req), .busy(div_busy), .quotient(div_quo)
   );

   // shared multiplier: magnitudes, registered, then shifted and signed
   logic [32:0] amag, bmag;
   assign amag = ma_in[32] ? 33'(-ma_in) : 33'(ma_in);
   assign bmag = mb_in[32] ? 33'(-mb_in) : 33'(mb_in);
   logic [65:0] shm;
   assign shm  = prod_ff >> msh_ff;
   assign mres = mneg_ff ? -$signed(shm) : $signed(shm);

   always_ff @(posedge clock) begin
      prod_ff <= 66'(amag) * 66'(bmag);
      mneg_ff <= ma_in[32] ^ mb_in[32];
      msh_ff  <= msh_in;
   end

   always_comb begin
      st_in = st_ff; ang_in = ang_ff; bias_in = bias_ff;
      for (int i = 0; i < 4; i++) p_in[i] = p_ff[i];
      meas_in = meas_ff; gyro_in = gyro_ff; pa_in = pa_ff;
      k0_in = k0_ff; k1_in = k1_ff; err_in = err_ff; epos_in = epos_ff; e_in = e_ff;
      out_valid_in = out_valid_ff; out_ang_in = out_ang_ff; out_rate_in = out_rate_ff;
      ma_in = '0; mb_in = '0; msh_in = 7'(CF);
      div_req = '0;
      qa_c = cfg_cov(qa_ff); qb_c = cfg_cov(qb_ff); r_c = cfg_cov(r_ff);
      t0 = '0; t1 = '0;
      rate = '0; rmag = '0; whole = '0;
      if (out_valid_ff && rsp.ready) out_valid_in = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            if (req.valid) begin
               meas_in = req.data[31:0];
               gyro_in = req.data[63:32];
               st_in = ST_M_ANG;
            end
         end
         ST_M_ANG: begin
            ma_in = 33'(gyro_ff) - 33'(bias_ff); mb_in = $signed({1'b0, dt_ff});
            st_in = ST_A_ANG;
         end
         ST_A_ANG: begin
            ang_in = 32'(abkf_pkg::sat32(66'(ang_ff) + mres));
            t0 = abkf_pkg::sat32(qa_c - 66'(p_ff[1]) - 66'(p_ff[2]));
            ma_in = 33'(t0); mb_in = $signed({1'b0, dt_ff});
            st_in = ST_A_P00;
         end
         ST_A_P00: begin
            p_in[0] = 32'(abkf_pkg::sat32(66'(p_ff[0]) + mres));
            t0 = abkf_pkg::sat32(-66'(p_ff[3]));
            ma_in = 33'(t0); mb_in = $signed({1'b0, dt_ff});
            st_in = ST_A_P01;
         end
         ST_A_P01: begin
            p_in[1] = 32'(abkf_pkg::sat32(66'(p_ff[1]) + mres));
            p_in[2] = 32'(abkf_pkg::sat32(66'(p_ff[2]) + mres));
            t0 = abkf_pkg::sat32(qb_c);
            ma_in = 33'(t0); mb_in = $signed({1'b0, dt_ff});
            st_in = ST_A_P11;
         end
         ST_A_P11: begin
            p_in[3] = 32'(abkf_pkg::sat32(66'(p_ff[3]) + mres));
            err_in = 33'(meas_ff) - 33'(ang_ff);
            t1 = r_c + 66'(p_ff[0]);
            epos_in = (t1 > 0);
            e_in = 64'(t1);
            st_in = ST_DIV0;
         end
         ST_DIV0: begin
            if (epos_ff) begin
               div_req.start = 1'b1;
               div_req.dividend = 64'(p_ff[0][31] ? 33'(-33'(p_ff[0])) : 33'(p_ff[0]))
                                  << COV_FRAC_BITS;
               div_req.divisor = e_ff;
               st_in = ST_W0;
            end else begin
               k0_in = '0; k1_in = '0; st_in = ST_M_N00;
            end
         end
         ST_W0: begin
            if (!div_busy) begin
               t0 = (div_quo > 64'd2147483648) ? 66'sd2147483648 : $signed(66'(div_quo));
               t0 = pneg_ff ? -t0 : t0;
               k0_in = 32'(abkf_pkg::sat32(t0));
               div_req.start = 1'b1;
               div_req.dividend = 64'(p_ff[2][31] ? 33'(-33'(p_ff[2])) : 33'(p_ff[2]))
                                  << COV_FRAC_BITS;
               div_req.divisor = e_ff;
               st_in = ST_W1;
            end
         end
         ST_W1: begin
            if (!div_busy && !div_req.start) begin
               t0 = (div_quo > 64'd2147483648) ? 66'sd2147483648 : $signed(66'(div_quo));
               t0 = pneg_ff ? -t0 : t0;
               k1_in = 32'(abkf_pkg::sat32(t0));
               st_in = ST_M_N00;
            end
         end
         ST_M_N00: begin
            ma_in = 33'(k0_ff); mb_in = 33'(p_ff[0]); msh_in = 7'(COV_FRAC_BITS);
            st_in = ST_A_N00;
         end
         ST_A_N00: begin
            pa_in = 32'(abkf_pkg::sat32(66'(p_ff[0]) - mres));
            ma_in = 33'(k1_ff); mb_in = 33'(p_ff[0]); msh_in = 7'(COV_FRAC_BITS);
            st_in = ST_A_N10;
         end
         ST_A_N10: begin
            p_in[2] = 32'(abkf_pkg::sat32(66'(p_ff[2]) - mres));
            ma_in = 33'(k1_ff); mb_in = 33'(p_ff[1]); msh_in = 7'(COV_FRAC_BITS);
            st_in = ST_A_N11;
         end
         ST_A_N11: begin
            p_in[3] = 32'(abkf_pkg::sat32(66'(p_ff[3]) - mres));
            ma_in = 33'(k0_ff); mb_in = 33'(p_ff[1]); msh_in = 7'(COV_FRAC_BITS);
            st_in = ST_A_N01;
         end
         ST_A_N01: begin
            p_in[1] = 32'(abkf_pkg::sat32(66'(p_ff[1]) - mres));
            p_in[0] = pa_ff;
            ma_in = 33'(k0_ff); mb_in = err_ff; msh_in = 7'(COV_FRAC_BITS);
            st_in = ST_A_CA;
         end
         ST_A_CA: begin
            ang_in = 32'(abkf_pkg::sat32(66'(ang_ff) + mres));
            ma_in = 33'(k1_ff); mb_in = err_ff; msh_in = 7'(COV_FRAC_BITS);
            st_in = ST_A_CB;
         end
         ST_A_CB: begin
            bias_in = 32'(abkf_pkg::sat32(66'(bias_ff) + mres));
            st_in = ST_OUT;
         end
         ST_OUT: begin
            if (!out_valid_ff || rsp.ready) begin
               rate = 34'(gyro_ff) - 34'(bias_ff);
               rmag = rate[33] ? 34'(-rate) : 34'(rate);
               whole = rate[33] ? -$signed(34'(rmag >> 16)) : $signed(34'(rmag >> 16));
               if (whole > 34'sd32767) whole = 34'sd32767;
               if (whole < -34'sd32768) whole = -34'sd32768;
               out_rate_in = 16'(whole);
               out_ang_in = ang_ff;
               out_valid_in = 1'b1;
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   // sign of the numerator being divided
   always_ff @(posedge clock) begin
      if (st_ff == ST_DIV0) pneg_ff <= p_ff[0][31];
      else if (st_ff == ST_W0 && !div_busy) pneg_ff <= p_ff[2][31];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         qa_ff <= abkf_pkg::RST_ANGLE_NOISE; qb_ff <= abkf_pkg::RST_BIAS_NOISE;
         r_ff <= abkf_pkg::RST_MEAS_NOISE; dt_ff <= abkf_pkg::RST_TIME_STEP;
         ang_ff <= '0; bias_ff <= '0;
         p_ff[0] <= 32'sd1 <<< COV_FRAC_BITS; p_ff[1] <= '0;
         p_ff[2] <= '0; p_ff[3] <= 32'sd1 <<< COV_FRAC_BITS;
         out_valid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         ang_ff <= ang_in; bias_ff <= bias_in;
         for (int i = 0; i < 4; i++) p_ff[i] <= p_in[i];
         out_valid_ff <= out_valid_in;
         if (csr_write) begin
            unique case (csr_index)
               abkf_pkg::CSR_ANGLE_NOISE: qa_ff <= csr_data;
               abkf_pkg::CSR_BIAS_NOISE:  qb_ff <= csr_data;
               abkf_pkg::CSR_MEAS_NOISE:  r_ff  <= csr_data;
               abkf_pkg::CSR_TIME_STEP:   dt_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      meas_ff <= meas_in; gyro_ff <= gyro_in; pa_ff <= pa_in;
      k0_ff <= k0_in; k1_ff <= k1_in; err_ff <= err_in;
      epos_ff <= epos_in; e_ff <= e_in;
      out_ang_ff <= out_ang_in; out_rate_ff <= out_rate_in;
   end

   assign req.ready = (st_ff == ST_IDLE);
   assign rsp.valid = out_valid_ff;
   assign rsp.data  = {out_rate_ff, out_ang_ff};

   `ASSERT_NEXT(a_busy_after_beat, clock, reset, req.valid && req.ready, !req.ready,
                "ready stayed high after a beat")
   `ASSERT_IMPL(a_idle_when_ready, clock, reset, req.ready, !div_busy,
                "divider busy while idle")
   `ASSERT_NEXT(a_out_from_seq, clock, reset, !rsp.valid && st_ff != ST_OUT, !rsp.valid,
                "result without finishing a step")
endmodule
`default_nettype wire

/* sv/abkf_divider.sv */
// restoring unsigned divider, one quotient bit per cycle
`default_nettype none
module abkf_divider (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire abkf_pkg::div_req_type req,
   output logic                      busy,
   output logic [63:0]               quotient
);
   logic [63:0]  quo_ff, quo_in;
   logic [63:0]  rem_ff, rem_in;
   logic [63:0]  dsr_ff, dsr_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic [64:0]  trial;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      cnt_in = cnt_ff;
      trial  = {rem_ff, quo_ff[63]} - {1'b0, dsr_ff};
      if (req.start) begin
         quo_in = req.dividend;
         rem_in = '0;
         dsr_in = req.divisor;
         cnt_in = 7'd64;
      end else if (cnt_ff != 7'd0) begin
         if (!trial[64]) begin
            rem_in = trial[63:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = {rem_ff[62:0], quo_ff[63]};
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      if (reset) cnt_ff <= '0;
      else cnt_ff <= cnt_in;
   end

   assign busy     = (cnt_ff != 7'd0);
   assign quotient = quo_ff;
endmodule
`default_nettype wire

/* tb/angle_bias_kalman_filter_checker.sv */
// checker for the angle bias kalman filter: predicts each result and compares beats
module angle_bias_kalman_filter_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   abkf_stream_if           req,
   abkf_stream_if           rsp,
   input  wire logic        csr_write,
   input  wire logic [abkf_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  wire logic [31:0] csr_data,
   output int               fail_count,
   output int               pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [65:0] wide_type;
   typedef struct {
      logic signed [31:0] angle;
      logic signed [15:0] rate;
   } filter_out_type;

   localparam int FRAC = abkf_pkg::COV_FRAC_BITS;
   localparam int CFRAC = abkf_pkg::CFG_FRAC_BITS;

   logic [31:0]        angle_noise, bias_noise, meas_noise, time_step;
   logic signed [31:0] angle_est, bias_est;
   logic signed [31:0] cov [4];
   filter_out_type     expected_q [$];

   function automatic wide_type clamp32(input wide_type v);
      if (v > 66'sd2147483647) return 66'sd2147483647;
      if (v < -66'sd2147483648) return -66'sd2147483648;
      return v;
   endfunction

   function automatic logic [65:0] abs_of(input wide_type v);
      return v < 0 ? -v : v;
   endfunction

   function automatic wide_type scaled_product(input wide_type a, input wide_type b,
                                               input int sh);
      logic [131:0] m;
      m = ({66'd0, abs_of(a)} * {66'd0, abs_of(b)}) >> sh;
      return ((a < 0) != (b < 0)) ? -$signed(m[65:0]) : $signed(m[65:0]);
   endfunction

   function automatic wide_type gain_of(input wide_type p, input wide_type e);
      logic [131:0] q;
      q = ({66'd0, abs_of(p)} << FRAC) / {66'd0, e[65:0]};
      return clamp32(p < 0 ? -$signed(q[65:0]) : $signed(q[65:0]));
   endfunction

   task automatic filter_step(input logic signed [31:0] meas_in,
                              input logic signed [31:0] gyro_in);
      wide_type meas, gyro, dt, p00, p01, p10, p11, ang, bias;
      wide_type d0, d1, d3, err, e, k0, k1, rt, whole;
      filter_out_type res;
      meas = meas_in;
      gyro = gyro_in;
      dt   = {34'd0, time_step};
      p00 = cov[0]; p01 = cov[1]; p10 = cov[2]; p11 = cov[3];
      ang = clamp32(wide_type'(angle_est) + scaled_product(gyro - bias_est, dt, CFRAC));
      d0  = clamp32({34'd0, angle_noise} - p01 - p10);
      d1  = clamp32(-p11);
      d3  = clamp32({34'd0, bias_noise});
      p00 = clamp32(p00 + scaled_product(d0, dt, CFRAC));
      p01 = clamp32(p01 + scaled_product(d1, dt, CFRAC));
      p10 = clamp32(p10 + scaled_product(d1, dt, CFRAC));
      p11 = clamp32(p11 + scaled_product(d3, dt, CFRAC));
      err = meas - ang;
      e   = {34'd0, meas_noise} + p00;
      if (e > 0) begin
         k0 = gain_of(p00, e);
         k1 = gain_of(p10, e);
      end else begin
         k0 = '0;
         k1 = '0;
      end
      cov[0] = 32'(clamp32(p00 - scaled_product(k0, p00, FRAC)));
      cov[1] = 32'(clamp32(p01 - scaled_product(k0, p01, FRAC)));
      cov[2] = 32'(clamp32(p10 - scaled_product(k1, p00, FRAC)));
      cov[3] = 32'(clamp32(p11 - scaled_product(k1, p01, FRAC)));
      ang  = clamp32(ang + scaled_product(k0, err, FRAC));
      bias = clamp32(wide_type'(bias_est) + scaled_product(k1, err, FRAC));
      angle_est = ang[31:0];
      bias_est  = bias[31:0];
      rt    = gyro - bias;
      whole = abs_of(rt) >> 16;
      if (rt < 0) whole = -whole;
      if (whole > 32767) whole = 32767;
      if (whole < -32768) whole = -32768;
      res.angle = angle_est;
      res.rate  = whole[15:0];
      expected_q.push_back(res);
   endtask

   always @(posedge clock) begin
      filter_out_type want;
      if (reset) begin
         angle_noise = abkf_pkg::RST_ANGLE_NOISE;
         bias_noise  = abkf_pkg::RST_BIAS_NOISE;
         meas_noise  = abkf_pkg::RST_MEAS_NOISE;
         time_step   = abkf_pkg::RST_TIME_STEP;
         angle_est   = '0;
         bias_est    = '0;
         cov[0] = 32'sd1 <<< FRAC; cov[1] = '0; cov[2] = '0; cov[3] = 32'sd1 <<< FRAC;
         expected_q.delete();
         fail_count = 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               abkf_pkg::CSR_ANGLE_NOISE: angle_noise = csr_data;
               abkf_pkg::CSR_BIAS_NOISE:  bias_noise  = csr_data;
               abkf_pkg::CSR_MEAS_NOISE:  meas_noise  = csr_data;
               abkf_pkg::CSR_TIME_STEP:   time_step   = csr_data;
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected result beat: %h", rsp.data);
            end else begin
               want = expected_q.pop_front();
               if (rsp.data[31:0] !== want.angle || rsp.data[47:32] !== want.rate) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: angle exp %h got %h, rate exp %h got %h",
                        want.angle, rsp.data[31:0], want.rate, rsp.data[47:32]);
               end
            end
         end
         if (req.valid && req.ready) filter_step(req.data[31:0], req.data[63:32]);
      end
      pending = expected_q.size();
   end
endmodule

/* tb/angle_bias_kalman_filter_unit_tb.sv */
// testbench top for the angle bias kalman filter: stimulus, stalls and verdict
module angle_bias_kalman_filter_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 2000000;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_write = 0;
   logic [abkf_pkg::CSR_IDX_WIDTH-1:0] csr_index = abkf_pkg::CSR_ANGLE_NOISE;
   logic [31:0] csr_data = 0;
   int          fail_count, pending, cycles = 0;
   logic        stall_free = 0;

   abkf_stream_if #(.WIDTH(64)) req (.clock(clock));
   abkf_stream_if #(.WIDTH(48)) rsp (.clock(clock));

   angle_bias_kalman_filter_unit uut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   angle_bias_kalman_filter_checker checker_i (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .pending(pending)
   );

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // receiver stall pattern
   always @(negedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_free <= !stall_free;
      if (reset) rsp.ready <= 0;
      else rsp.ready <= stall_free || ($urandom_range(0, 3) != 0);
   end

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'h7fffffff;
         2: return 32'h80000000;
         default: return $urandom_range(0, 180 << 16) - (90 << 16);
      endcase
   endfunction

   task automatic send_beat(input logic [31:0] meas, input logic [31:0] gyro);
      req.data  <= {gyro, meas};
      req.valid <= 1;
      do @(posedge clock); while (!req.ready);
      @(negedge clock);
   endtask

   task automatic idle_gap();
      if ($urandom_range(0, 3) == 0) begin
         req.valid <= 0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   endtask

   task automatic drain();
      req.valid <= 0;
      while (pending != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   task automatic write_regs(input logic [31:0] qa, input logic [31:0] qb,
                             input logic [31:0] r, input logic [31:0] dt);
      drain();
      csr_write <= 1;
      csr_index <= abkf_pkg::CSR_ANGLE_NOISE; csr_data <= qa; @(negedge clock);
      csr_index <= abkf_pkg::CSR_BIAS_NOISE;  csr_data <= qb; @(negedge clock);
      csr_index <= abkf_pkg::CSR_MEAS_NOISE;  csr_data <= r;  @(negedge clock);
      csr_index <= abkf_pkg::CSR_TIME_STEP;   csr_data <= dt; @(negedge clock);
      csr_write <= 0;
      @(negedge clock);
   endtask

   task automatic random_run(input int count);
      for (int i = 0; i < count; i++) begin
         send_beat(pick_value(), pick_value());
         idle_gap();
      end
   endtask

   initial begin
      logic [31:0] corners [4];
      corners = '{32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff};
      req.valid = 0;
      req.data  = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      foreach (corners[a])
         foreach (corners[b]) send_beat(corners[a], corners[b]);
      // quiet sensor, then large steps
      send_beat(32'h0, 32'h0);
      send_beat(32'h005a0000, 32'h00010000);
      send_beat(32'hffa60000, 32'hffff0000);
      // zero process noise, smallest measurement noise and a very short step
      write_regs(32'h0, 32'h0, 32'h1, 32'h1);
      send_beat(32'h00010000, 32'h7fffffff);
      send_beat(32'h80000000, 32'h80000000);
      // largest noise and step
      write_regs(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
      send_beat(32'h7fffffff, 32'h80000000);
      send_beat(32'h12345678, 32'hedcba987);

      write_regs(abkf_pkg::RST_ANGLE_NOISE, abkf_pkg::RST_BIAS_NOISE,
                 abkf_pkg::RST_MEAS_NOISE, abkf_pkg::RST_TIME_STEP);
      random_run(450);
      drain();
      random_run(400);
      write_regs($urandom(), $urandom(), $urandom_range(1, 32'hffffffff),
                 $urandom_range(1, 32'hffffffff));
      random_run(300);
      write_regs($urandom_range(0, 1 << 20), $urandom_range(0, 1 << 20),
                 $urandom_range(1, 1 << 26), $urandom_range(1, 1 << 24));
      random_run(300);
      write_regs(32'h0, 32'hffffffff, 32'h1, $urandom_range(1, 32'hffffffff));
      random_run(300);
      drain();

      if (fail_count == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end
endmodule

/* files.f */
+incdir+sv
sv/abkf_pkg.sv
sv/abkf_stream_if.sv
sv/abkf_divider.sv
sv/angle_bias_kalman_filter_unit.sv
tb/angle_bias_kalman_filter_checker.sv
tb/angle_bias_kalman_filter_unit_tb.sv
